// ----- rtl/eth_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// Shared types, widths and helpers of the event transition histogram.
// No dependencies.
package eth_pkg;

  localparam int PARTICLES   = 1024;
  localparam int SOURCES     = 16;
  localparam int EVENT_TYPES = 8;
  localparam int KEYS        = SOURCES * EVENT_TYPES;
  localparam int CELLS       = KEYS * KEYS;

  localparam int PART_W = $clog2(PARTICLES);
  localparam int SRC_W  = $clog2(SOURCES);
  localparam int TYPE_W = $clog2(EVENT_TYPES);
  localparam int KEY_W  = SRC_W + TYPE_W;
  localparam int CELL_W = 2 * KEY_W;
  localparam int TIME_W = 48;
  localparam int CNT_W  = 32;
  localparam int SUM_W  = 64;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LOOKUP,
    ST_CELL,
    ST_UPDATE
  } state_t;

  typedef struct packed {
    logic              valid;
    logic [KEY_W-1:0]  key;
    logic [TIME_W-1:0] stamp;
  } part_entry_t;

  typedef struct packed {
    logic [CNT_W-1:0] count;
    logic [SUM_W-1:0] tsum;
  } cell_entry_t;

  function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
    sat_inc = (&v) ? v : v + CNT_W'(1);
  endfunction

  function automatic logic [SUM_W-1:0] sat_add(input logic [SUM_W-1:0] a,
                                               input logic [TIME_W-1:0] b);
    logic [SUM_W:0] s;
    s = {1'b0, a} + (SUM_W + 1)'(b);
    sat_add = s[SUM_W] ? {SUM_W{1'b1}} : s[SUM_W-1:0];
  endfunction

endpackage
`default_nettype wire

// ----- rtl/event_transition_histogram_core.sv -----
`timescale 1ns / 1ps
`default_nettype none
// Top level of the event transition histogram: control, tables and result register.
// Depends on eth_pkg and eth_ram.
//
// Each accepted item passes through accept, particle table read, cell table read
// and update in that order, set by the two dependent registered reads of the
// particle table and then of the transition or first-event table; the next item
// is taken once the update is written, and the update waits only while the
// result register is still full and stalled. After reset a clearing pass zeroes
// all tables, during which no item is accepted.
module event_transition_histogram_core (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [eth_pkg::PART_W-1:0]   in_particle,
  input  logic [eth_pkg::SRC_W-1:0]    in_source,
  input  logic [eth_pkg::TYPE_W-1:0]   in_event_type,
  input  logic [eth_pkg::TIME_W-1:0]   in_timestamp,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic                         out_first_event,
  output logic [eth_pkg::SRC_W-1:0]    out_previous_source,
  output logic [eth_pkg::TYPE_W-1:0]   out_previous_type,
  output logic [eth_pkg::TIME_W-1:0]   out_elapsed,
  output logic [eth_pkg::CNT_W-1:0]    out_cell_count,
  output logic [eth_pkg::SUM_W-1:0]    out_cell_time,
  output logic [eth_pkg::CNT_W-1:0]    out_total_transitions
);
  import eth_pkg::*;

  state_t state_r, state_nxt;

  logic [CELL_W-1:0] clr_cnt_r;
  logic [PART_W-1:0] particle_r;
  logic [KEY_W-1:0]  key_r;
  logic [KEY_W-1:0]  prev_key_r;
  logic [TIME_W-1:0] now_r;
  logic [TIME_W-1:0] elapsed_r;
  logic              first_r;
  logic [CNT_W-1:0]  cnt_r;
  logic [SUM_W-1:0]  tsum_r;
  logic [CNT_W-1:0]  total_r;
  logic [CNT_W-1:0]  total_inc;

  logic out_valid_r;
  logic out_free;
  logic in_accept;
  logic commit;

  logic              part_we, part_re;
  logic [PART_W-1:0] part_waddr;
  part_entry_t       part_wdata, part_rdata;

  logic              cell_we, cell_re;
  logic [CELL_W-1:0] cell_waddr, cell_raddr;
  cell_entry_t       cell_wdata, cell_rdata;

  logic              init_we, init_re;
  logic [KEY_W-1:0]  init_waddr;
  logic [CNT_W-1:0]  init_wdata, init_rdata;

  eth_ram #(.WIDTH($bits(part_entry_t)), .DEPTH(PARTICLES)) u_part_ram (
    .clk   (clk),
    .we    (part_we),
    .waddr (part_waddr),
    .wdata (part_wdata),
    .re    (part_re),
    .raddr (in_particle),
    .rdata (part_rdata)
  );

  eth_ram #(.WIDTH($bits(cell_entry_t)), .DEPTH(CELLS)) u_cell_ram (
    .clk   (clk),
    .we    (cell_we),
    .waddr (cell_waddr),
    .wdata (cell_wdata),
    .re    (cell_re),
    .raddr (cell_raddr),
    .rdata (cell_rdata)
  );

  eth_ram #(.WIDTH(CNT_W), .DEPTH(KEYS)) u_init_ram (
    .clk   (clk),
    .we    (init_we),
    .waddr (init_waddr),
    .wdata (init_wdata),
    .re    (init_re),
    .raddr (key_r),
    .rdata (init_rdata)
  );

  assign out_free  = !out_valid_r || !out_stall;
  assign in_accept = in_valid && !in_stall;
  assign total_inc = sat_inc(total_r);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_CLEAR:  if (&clr_cnt_r) state_nxt = ST_IDLE;
      ST_IDLE:   if (in_valid) state_nxt = ST_LOOKUP;
      ST_LOOKUP: state_nxt = ST_CELL;
      ST_CELL:   state_nxt = ST_UPDATE;
      ST_UPDATE: if (out_free) state_nxt = ST_IDLE;
      default:   state_nxt = ST_CLEAR;
    endcase
  end

  always_comb begin
    in_stall   = 1'b1;
    part_re    = 1'b0;
    cell_re    = 1'b0;
    init_re    = 1'b0;
    commit     = 1'b0;
    part_we    = 1'b0;
    cell_we    = 1'b0;
    init_we    = 1'b0;
    part_waddr = particle_r;
    part_wdata = '{valid: 1'b1, key: key_r, stamp: now_r};
    cell_waddr = {key_r, prev_key_r};
    cell_wdata = '{count: cnt_r, tsum: tsum_r};
    init_waddr = key_r;
    init_wdata = cnt_r;
    cell_raddr = {key_r, part_rdata.key};
    unique case (state_r)
      ST_CLEAR: begin
        part_we    = 1'b1;
        cell_we    = 1'b1;
        init_we    = 1'b1;
        part_waddr = clr_cnt_r[PART_W-1:0];
        part_wdata = '0;
        cell_waddr = clr_cnt_r;
        cell_wdata = '0;
        init_waddr = clr_cnt_r[KEY_W-1:0];
        init_wdata = '0;
      end
      ST_IDLE: begin
        in_stall = 1'b0;
        part_re  = in_valid;
      end
      ST_LOOKUP: begin
        cell_re = part_rdata.valid;
        init_re = !part_rdata.valid;
      end
      ST_CELL: begin
      end
      ST_UPDATE: begin
        commit  = out_free;
        part_we = out_free;
        cell_we = out_free && !first_r;
        init_we = out_free && first_r;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_cnt_r   <= '0;
      total_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == ST_CLEAR) begin
        clr_cnt_r <= clr_cnt_r + CELL_W'(1);
      end
      if (commit && !first_r) begin
        total_r <= total_inc;
      end
      if (commit) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      particle_r <= in_particle;
      key_r      <= {in_source, in_event_type};
      now_r      <= in_timestamp;
    end
    if (state_r == ST_LOOKUP) begin
      first_r <= !part_rdata.valid;
      if (part_rdata.valid) begin
        prev_key_r <= part_rdata.key;
        elapsed_r  <= (now_r >= part_rdata.stamp) ? now_r - part_rdata.stamp : '0;
      end else begin
        prev_key_r <= '0;
        elapsed_r  <= '0;
      end
    end
    if (state_r == ST_CELL) begin
      if (first_r) begin
        cnt_r  <= sat_inc(init_rdata);
        tsum_r <= '0;
      end else begin
        cnt_r  <= sat_inc(cell_rdata.count);
        tsum_r <= sat_add(cell_rdata.tsum, elapsed_r);
      end
    end
    if (commit) begin
      out_first_event       <= first_r;
      out_previous_source   <= prev_key_r[KEY_W-1:TYPE_W];
      out_previous_type     <= prev_key_r[TYPE_W-1:0];
      out_elapsed           <= elapsed_r;
      out_cell_count        <= cnt_r;
      out_cell_time         <= tsum_r;
      out_total_transitions <= first_r ? total_r : total_inc;
    end
  end

  assign out_valid = out_valid_r;

`ifndef ASSERT_OFF
  a_no_accept_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_CLEAR |-> in_stall)
    else $error("Item accepted during the clearing pass.");

  a_single_table_write: assert property (@(posedge clk) disable iff (!rst_n)
    state_r != ST_CLEAR |-> !(cell_we && init_we))
    else $error("Cell and first-event tables written for the same item.");

  a_update_returns_idle: assert property (@(posedge clk) disable iff (!rst_n)
    commit |=> state_r == ST_IDLE && out_valid_r)
    else $error("Update did not complete into the result register.");

  a_total_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
    state_r != ST_CLEAR |=> total_r >= $past(total_r))
    else $error("Transition total decreased.");

  a_first_keeps_total: assert property (@(posedge clk) disable iff (!rst_n)
    commit && first_r |=> total_r == $past(total_r))
    else $error("First event changed the transition total.");
`endif

endmodule
`default_nettype wire

// ----- rtl/eth_ram.sv -----
`timescale 1ns / 1ps
`default_nettype none
// Generic simple dual-port RAM: one write port, one read port with registered data.
// No dependencies.
module eth_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule
`default_nettype wire
